[rtl/hbc_pkg.sv]
// Shared types, sizes and codes for the hashed block buffer cache.
// No dependencies; every other file refers to it by scoped names.
package hbc_pkg;

  localparam int NUM_BUFFERS = 32;
  localparam int NUM_BUCKETS = 13;

  localparam int IDX_W  = $clog2(NUM_BUFFERS);
  localparam int BKT_W  = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int BLK_W  = 32;
  localparam int SCAN_LAST = NUM_BUFFERS;
  localparam int CNT_W  = $clog2(SCAN_LAST + 1);

  // bucket = blk - NUM_BUCKETS * ((blk * BKT_RECIP) >> BKT_SHIFT), exact for any blk
  localparam int          BKT_L     = $clog2(NUM_BUCKETS);
  localparam int          BKT_SHIFT = BLK_W + BKT_L;
  localparam logic [63:0] BKT_ONE   = 64'd1 << BKT_SHIFT;
  localparam logic [BLK_W:0] BKT_RECIP =
    (BLK_W + 1)'((BKT_ONE + 64'(NUM_BUCKETS) - 64'd1) / 64'(NUM_BUCKETS));

  localparam logic [7:0] REF_MAX = 8'd255;

  localparam logic [2:0] REQ_READ    = 3'd0;
  localparam logic [2:0] REQ_WRITE   = 3'd1;
  localparam logic [2:0] REQ_RELEASE = 3'd2;
  localparam logic [2:0] REQ_PIN     = 3'd3;
  localparam logic [2:0] REQ_UNPIN   = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_FREE = 2'd1;
  localparam logic [1:0] ST_RANGE   = 2'd2;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [7:0]  device_id;
    logic [31:0] block_number;
    logic [4:0]  buffer_index;
  } in_word_t;

  typedef struct packed {
    logic [4:0] granted_buffer;
    logic       hit;
    logic       disk_read_needed;
    logic       disk_write_needed;
    logic [1:0] status;
  } out_word_t;

  // one buffer's tag entry
  typedef struct packed {
    logic [7:0]       dev;
    logic [BLK_W-1:0] blk;
    logic [BKT_W-1:0] bkt;
    logic             vld;
    logic [7:0]       refc;
    logic [IDX_W-1:0] rank;
  } ent_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    ent_t             data;
  } wr_port_t;

endpackage

[rtl/hbc_tag_ram.sv]
// Tag entry memory: one write port, one read port, registered read data.
// Depends on hbc_pkg.
module hbc_tag_ram (
  input  logic                    clk,
  input  logic [hbc_pkg::IDX_W-1:0] rd_addr,
  input  hbc_pkg::wr_port_t       wr,
  output hbc_pkg::ent_t           rd_data
);

  hbc_pkg::ent_t mem [hbc_pkg::NUM_BUFFERS];
  hbc_pkg::ent_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/hbc_bucket_div.sv]
// Remainder of a block number by the bucket count, two-stage reciprocal multiply.
// Depends on hbc_pkg.
module hbc_bucket_div (
  input  logic                      clk,
  input  logic [hbc_pkg::BLK_W-1:0] blk,
  output logic [hbc_pkg::BKT_W-1:0] rem
);

  localparam int PW = 2 * hbc_pkg::BLK_W + 1;

  logic [PW-1:0]             prod_r;
  logic [hbc_pkg::BLK_W-1:0] blk_r;
  logic [hbc_pkg::BLK_W-1:0] quo;
  logic [hbc_pkg::BLK_W-1:0] rem_full;
  logic [hbc_pkg::BKT_W-1:0] rem_r;

  // stage 2: quotient from the product, then remainder
  always_comb begin
    quo      = hbc_pkg::BLK_W'(prod_r >> hbc_pkg::BKT_SHIFT);
    rem_full = blk_r - hbc_pkg::BLK_W'(quo * hbc_pkg::BLK_W'(hbc_pkg::NUM_BUCKETS));
  end

  always_ff @(posedge clk) begin
    prod_r <= PW'(blk) * PW'(hbc_pkg::BKT_RECIP);
    blk_r  <= blk;
    rem_r  <= hbc_pkg::BKT_W'(rem_full);
  end

  assign rem = rem_r;

endmodule

[rtl/hashed_block_buffer_cache_unit.sv]
// Top level of the hashed block buffer cache tag manager: sequencer,
// result register. Depends on hbc_pkg, hbc_tag_ram, hbc_bucket_div.
//
//  channel | ports                      | word
//  --------+----------------------------+-------------------------
//  request | in_valid, in_stall, in_word   | hbc_pkg::in_word_t
//  result  | out_valid, out_stall, out_word| hbc_pkg::out_word_t
//
// A read scans all tag entries one per cycle through the single read port
// (hit and free-victim searches share the pass; the block's bucket comes from
// a two-stage reciprocal multiply that settles during the scan). A miss or a
// release to zero adds a recency sweep over all entries. Write and
// out-of-range requests go from idle straight to emit; pin/unpin/release
// pass through a single-entry update first. The emit cycle repeats while an
// earlier result waits. After reset a fill pass writes every entry; in_stall
// stays high meanwhile. A new word is taken while a result waits.
module hashed_block_buffer_cache_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  hbc_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output hbc_pkg::out_word_t out_word
);

  localparam logic [2:0] S_INIT   = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_DECIDE = 3'd3;
  localparam logic [2:0] S_SINGLE = 3'd4;
  localparam logic [2:0] S_SWEEP  = 3'd5;
  localparam logic [2:0] S_EMIT   = 3'd6;

  localparam int IW = hbc_pkg::IDX_W;
  localparam int CW = hbc_pkg::CNT_W;

  logic [2:0]            state_r, state_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  hbc_pkg::in_word_t     req_r, req_nxt;
  logic                  hit_fnd_r, hit_fnd_nxt;
  logic [IW-1:0]         hit_idx_r, hit_idx_nxt;
  hbc_pkg::ent_t         hit_ent_r, hit_ent_nxt;
  logic                  vic_fnd_r, vic_fnd_nxt;
  logic [IW-1:0]         vic_idx_r, vic_idx_nxt;
  logic [hbc_pkg::BKT_W-1:0] vic_bkt_r, vic_bkt_nxt;
  logic [IW-1:0]         vic_rank_r, vic_rank_nxt;
  hbc_pkg::ent_t         vrec_r, vrec_nxt;
  hbc_pkg::out_word_t    res_r, res_nxt;
  hbc_pkg::out_word_t    out_r, out_nxt;
  logic                  out_valid_r, out_valid_nxt;

  logic [IW-1:0]         rd_addr;
  hbc_pkg::wr_port_t     wr;
  hbc_pkg::ent_t         rd_data;
  logic [hbc_pkg::BKT_W-1:0] bkt_rem;

  logic                  accept;
  logic [IW-1:0]         prev_idx;
  logic [IW-1:0]         req_idx;
  hbc_pkg::ent_t         upd;

  hbc_tag_ram u_ram (
    .clk     (clk),
    .rd_addr (rd_addr),
    .wr      (wr),
    .rd_data (rd_data)
  );

  // bucket of the held request's block number, registered in the divider
  hbc_bucket_div u_div (
    .clk (clk),
    .blk (req_r.block_number),
    .rem (bkt_rem)
  );

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign prev_idx = IW'(cnt_r - CW'(1));
  assign req_idx  = IW'(req_r.buffer_index);

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    req_nxt      = req_r;
    hit_fnd_nxt  = hit_fnd_r;
    hit_idx_nxt  = hit_idx_r;
    hit_ent_nxt  = hit_ent_r;
    vic_fnd_nxt  = vic_fnd_r;
    vic_idx_nxt  = vic_idx_r;
    vic_bkt_nxt  = vic_bkt_r;
    vic_rank_nxt = vic_rank_r;
    vrec_nxt     = vrec_r;
    res_nxt      = res_r;
    out_nxt      = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    rd_addr      = cnt_r[IW-1:0];
    wr           = '0;
    upd          = rd_data;

    unique case (state_r)
      S_INIT: begin
        // fill pass: zero tags, rank of buffer k is NUM_BUFFERS-1-k
        wr.en        = 1'b1;
        wr.addr      = cnt_r[IW-1:0];
        wr.data      = '0;
        wr.data.rank = IW'(hbc_pkg::NUM_BUFFERS - 1) - cnt_r[IW-1:0];
        cnt_nxt      = cnt_r + CW'(1);
        if (cnt_r == CW'(hbc_pkg::NUM_BUFFERS - 1)) begin
          state_nxt = S_IDLE;
          cnt_nxt   = '0;
        end
      end

      S_IDLE: begin
        rd_addr   = IW'(in_word.buffer_index);
        if (accept) begin
          req_nxt     = in_word;
          cnt_nxt     = '0;
          hit_fnd_nxt = 1'b0;
          vic_fnd_nxt = 1'b0;
          res_nxt     = '0;
          if (in_word.req_type == hbc_pkg::REQ_READ) begin
            state_nxt = S_SCAN;
          end else if (in_word.req_type > hbc_pkg::REQ_UNPIN) begin
            state_nxt = S_EMIT;
          end else if (32'(in_word.buffer_index) >= hbc_pkg::NUM_BUFFERS) begin
            res_nxt.granted_buffer = in_word.buffer_index;
            state_nxt = S_EMIT;
          end else if (in_word.req_type == hbc_pkg::REQ_WRITE) begin
            res_nxt.granted_buffer    = in_word.buffer_index;
            res_nxt.disk_write_needed = 1'b1;
            state_nxt = S_EMIT;
          end else begin
            state_nxt = S_SINGLE;
          end
        end
      end

      S_SCAN: begin
        // read entry cnt, evaluate entry cnt-1 from the registered read
        if (cnt_r >= CW'(1) && cnt_r <= CW'(hbc_pkg::NUM_BUFFERS)) begin
          if (rd_data.dev == req_r.device_id &&
              rd_data.blk == req_r.block_number &&
              (!hit_fnd_r || rd_data.rank < hit_ent_r.rank)) begin
            hit_fnd_nxt = 1'b1;
            hit_idx_nxt = prev_idx;
            hit_ent_nxt = rd_data;
          end
          if (rd_data.refc == 8'd0 &&
              (!vic_fnd_r || rd_data.bkt < vic_bkt_r ||
               (rd_data.bkt == vic_bkt_r && rd_data.rank > vic_rank_r))) begin
            vic_fnd_nxt  = 1'b1;
            vic_idx_nxt  = prev_idx;
            vic_bkt_nxt  = rd_data.bkt;
            vic_rank_nxt = rd_data.rank;
          end
        end
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == CW'(hbc_pkg::SCAN_LAST)) begin
          state_nxt = S_DECIDE;
        end
      end

      S_DECIDE: begin
        cnt_nxt = '0;
        if (hit_fnd_r) begin
          res_nxt.granted_buffer = 5'(hit_idx_r);
          res_nxt.hit            = 1'b1;
          if (hit_ent_r.refc >= hbc_pkg::REF_MAX) begin
            res_nxt.status = hbc_pkg::ST_RANGE;
          end else begin
            res_nxt.disk_read_needed = !hit_ent_r.vld;
            wr.en        = 1'b1;
            wr.addr      = hit_idx_r;
            wr.data      = hit_ent_r;
            wr.data.refc = hit_ent_r.refc + 8'd1;
            wr.data.vld  = 1'b1;
          end
          state_nxt = S_EMIT;
        end else if (!vic_fnd_r) begin
          res_nxt.status = hbc_pkg::ST_NO_FREE;
          state_nxt = S_EMIT;
        end else begin
          res_nxt.granted_buffer   = 5'(vic_idx_r);
          res_nxt.disk_read_needed = 1'b1;
          vrec_nxt.dev  = req_r.device_id;
          vrec_nxt.blk  = req_r.block_number;
          vrec_nxt.bkt  = bkt_rem;
          vrec_nxt.vld  = 1'b1;
          vrec_nxt.refc = 8'd1;
          vrec_nxt.rank = '0;
          state_nxt = S_SWEEP;
        end
      end

      S_SINGLE: begin
        res_nxt.granted_buffer = req_r.buffer_index;
        state_nxt = S_EMIT;
        case (req_r.req_type)
          hbc_pkg::REQ_PIN: begin
            upd.refc = rd_data.refc + 8'd1;
            if (rd_data.refc >= hbc_pkg::REF_MAX) begin
              res_nxt.status = hbc_pkg::ST_RANGE;
            end
          end
          default: begin
            upd.refc = rd_data.refc - 8'd1;
            if (rd_data.refc == 8'd0) begin
              res_nxt.status = hbc_pkg::ST_RANGE;
            end
          end
        endcase
        if (res_nxt.status == hbc_pkg::ST_OK) begin
          wr.en   = 1'b1;
          wr.addr = req_idx;
          wr.data = upd;
          // release to zero: move to most recent
          if (req_r.req_type == hbc_pkg::REQ_RELEASE && upd.refc == 8'd0) begin
            vic_idx_nxt   = req_idx;
            vic_rank_nxt  = rd_data.rank;
            vrec_nxt      = upd;
            vrec_nxt.rank = '0;
            cnt_nxt       = '0;
            state_nxt     = S_SWEEP;
          end
        end
      end

      S_SWEEP: begin
        // ranks below the moved entry's old rank age by one
        if (cnt_r >= CW'(1)) begin
          if (prev_idx == vic_idx_r) begin
            wr.en   = 1'b1;
            wr.addr = prev_idx;
            wr.data = vrec_r;
          end else if (rd_data.rank < vic_rank_r) begin
            wr.en        = 1'b1;
            wr.addr      = prev_idx;
            wr.data      = rd_data;
            wr.data.rank = rd_data.rank + IW'(1);
          end
        end
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == CW'(hbc_pkg::NUM_BUFFERS)) begin
          state_nxt = S_EMIT;
        end
      end

      S_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      hit_fnd_r   <= 1'b0;
      vic_fnd_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      hit_fnd_r   <= hit_fnd_nxt;
      vic_fnd_r   <= vic_fnd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    hit_idx_r  <= hit_idx_nxt;
    hit_ent_r  <= hit_ent_nxt;
    vic_idx_r  <= vic_idx_nxt;
    vic_bkt_r  <= vic_bkt_nxt;
    vic_rank_r <= vic_rank_nxt;
    vrec_r     <= vrec_nxt;
    res_r      <= res_nxt;
    out_r      <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_r;

endmodule
